// File: rtl/foc_pkg.sv
// shared types, constants and helpers for the foc transform chain
`default_nettype none

package foc_pkg;

  // sample and angle formats
  localparam int SAMPLE_WIDTH = 16;
  localparam int ANGLE_BITS   = 12;
  localparam int PHASE_BITS   = 16;
  localparam int EXTRA_BITS   = 8;

  // transform constants, q15
  localparam logic signed [15:0] K_THIRD      = 16'sd10923;  // 1/3
  localparam logic signed [15:0] K_INV_SQRT3  = 16'sd18919;  // 1/sqrt3
  localparam logic signed [15:0] K_SQRT3_HALF = 16'sd28378;  // sqrt3/2

  // quarter-wave sine polynomial coefficients, q15
  localparam logic [15:0] POLY_A = 16'd51472;
  localparam logic [15:0] POLY_B = 16'd21024;
  localparam logic [15:0] POLY_C = 16'd2320;

  localparam logic [14:0] QUARTER  = 15'd16384;  // quarter turn in q14
  localparam logic [15:0] SINE_MAX = 16'd32768;  // exactly 1.0 in q15

  localparam int WIDE = 44;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [16:0]             trig_t;
  typedef logic signed [WIDE-1:0]         wide_t;

  typedef struct packed {
    sample_t                 phase_a;
    sample_t                 phase_b;
    sample_t                 phase_c;
    logic [ANGLE_BITS-1:0]   rotor_angle;
    sample_t                 q_reference;
  } in_t;

  typedef struct packed {
    sample_t drive_u;
    sample_t drive_v;
    sample_t drive_w;
  } out_t;

  localparam wide_t SAT_HI = wide_t'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1);
  localparam wide_t SAT_LO = -SAT_HI - wide_t'(1);

  // clamp a wide signed value to the sample range
  function automatic sample_t sat_sample(wide_t v);
    sample_t r;
    if (v > SAT_HI) begin
      r = sample_t'(SAT_HI);
    end else if (v < SAT_LO) begin
      r = sample_t'(SAT_LO);
    end else begin
      r = sample_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/foc_sincos.sv
// four-stage pipelined sine evaluator, quarter-wave polynomial
`default_nettype none

module foc_sincos (
  input  logic                            clk,
  input  logic [3:0]                      en,
  input  logic [foc_pkg::PHASE_BITS-1:0]  phase,
  output foc_pkg::trig_t                  value
);

  // stage 1: fold into first quarter, square
  logic [1:0]  quad;
  logic [14:0] low;
  logic [14:0] z_nxt;
  logic [29:0] zsq;
  logic [14:0] z2_nxt;

  assign quad   = phase[foc_pkg::PHASE_BITS-1 -: 2];
  assign low    = {1'b0, phase[foc_pkg::PHASE_BITS-3:0]};
  assign z_nxt  = quad[0] ? (foc_pkg::QUARTER - low) : low;
  assign zsq    = 30'(z_nxt) * 30'(z_nxt);
  assign z2_nxt = 15'((zsq + 30'd8192) >> 14);

  logic [14:0] s1_z_r, s1_z2_r;
  logic        s1_neg_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_z_r   <= z_nxt;
      s1_z2_r  <= z2_nxt;
      s1_neg_r <= quad[1];
    end
  end

  // stage 2: c * z^2
  logic [26:0] t_prod;
  logic [11:0] t_nxt;

  assign t_prod = 27'(foc_pkg::POLY_C) * 27'(s1_z2_r);
  assign t_nxt  = 12'((t_prod + 27'd8192) >> 14);

  logic [14:0] s2_z_r, s2_z2_r;
  logic [11:0] s2_t_r;
  logic        s2_neg_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_z_r   <= s1_z_r;
      s2_z2_r  <= s1_z2_r;
      s2_t_r   <= t_nxt;
      s2_neg_r <= s1_neg_r;
    end
  end

  // stage 3: (b - t) * z^2
  logic [14:0] b_minus_t;
  logic [29:0] u_prod;
  logic [14:0] u_nxt;

  assign b_minus_t = 15'(foc_pkg::POLY_B) - 15'(s2_t_r);
  assign u_prod    = 30'(b_minus_t) * 30'(s2_z2_r);
  assign u_nxt     = 15'((u_prod + 30'd8192) >> 14);

  logic [14:0] s3_z_r, s3_u_r;
  logic        s3_neg_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_z_r   <= s2_z_r;
      s3_u_r   <= u_nxt;
      s3_neg_r <= s2_neg_r;
    end
  end

  // stage 4: (a - u) * z, clamp, apply sign
  logic [15:0]    a_minus_u;
  logic [30:0]    s_prod;
  logic [15:0]    mag;
  logic [15:0]    mag_clamp;
  foc_pkg::trig_t value_nxt;

  assign a_minus_u = foc_pkg::POLY_A - 16'(s3_u_r);
  assign s_prod    = 31'(a_minus_u) * 31'(s3_z_r);
  assign mag       = 16'((s_prod + 31'd8192) >> 14);
  assign mag_clamp = (mag > foc_pkg::SINE_MAX) ? foc_pkg::SINE_MAX : mag;
  assign value_nxt = s3_neg_r ? -foc_pkg::trig_t'({1'b0, mag_clamp})
                              :  foc_pkg::trig_t'({1'b0, mag_clamp});

  foc_pkg::trig_t value_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

`default_nettype wire

// File: rtl/foc_transform_chain_unit.sv
// top level of the foc clarke/park transform chain
// throughput: one request per cycle unless the output stalls, ten-stage pipeline
// each stage holds its own valid bit, so bubbles collapse under output stalls
// reset (rst_n low, synchronous) clears all valid bits; payload is not reset
`default_nettype none

module foc_transform_chain_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  foc_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output foc_pkg::out_t  out_data
);

  localparam int NSTAGE = 10;

  typedef logic signed [24:0] ab_t;    // alpha/beta, 8 extra fraction bits
  typedef logic signed [41:0] prod1_t; // alpha/beta times trig
  typedef logic signed [25:0] err_t;   // d/q errors
  typedef logic signed [42:0] prod2_t; // error times trig
  typedef logic signed [26:0] ab2_t;   // inverse park outputs

  localparam foc_pkg::wide_t RND_U  = foc_pkg::wide_t'(1) <<< (foc_pkg::EXTRA_BITS - 1);
  localparam foc_pkg::wide_t RND_VW =
      foc_pkg::wide_t'(1) <<< (15 + foc_pkg::EXTRA_BITS - 1);

  // ---------------------------------------------------------------------
  // stage valid bits and per-stage enables
  // a stage loads when it is empty or when the next stage moves on
  // ---------------------------------------------------------------------
  logic [NSTAGE:1] vld_r, vld_nxt;
  logic [NSTAGE:1] en;

  always_comb begin
    en[NSTAGE] = !vld_r[NSTAGE] || out_ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt[1] = en[1] ? in_valid : vld_r[1];
    for (int k = 2; k <= NSTAGE; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld_r[NSTAGE];

  // ---------------------------------------------------------------------
  // sine and cosine, stages 1 to 4
  // cosine uses the phase advanced by a quarter turn
  // ---------------------------------------------------------------------
  logic [foc_pkg::PHASE_BITS-1:0] phase_s, phase_c;
  foc_pkg::trig_t                 sin_v, cos_v;

  assign phase_s = foc_pkg::PHASE_BITS'(in_data.rotor_angle)
                   << (foc_pkg::PHASE_BITS - foc_pkg::ANGLE_BITS);
  assign phase_c = phase_s + (foc_pkg::PHASE_BITS'(1) << (foc_pkg::PHASE_BITS - 2));

  foc_sincos u_sin (
    .clk   (clk),
    .en    (en[4:1]),
    .phase (phase_s),
    .value (sin_v)
  );

  foc_sincos u_cos (
    .clk   (clk),
    .en    (en[4:1]),
    .phase (phase_c),
    .value (cos_v)
  );

  // ---------------------------------------------------------------------
  // stage 1: clarke transform
  // alpha = (2a - b - c)/3, beta = (b - c)/sqrt3, kept with extra fraction bits
  // ---------------------------------------------------------------------
  logic signed [17:0] diff_a;
  logic signed [16:0] diff_bc;
  logic signed [31:0] alpha_prod, beta_prod;
  ab_t                alpha_nxt, beta_nxt;

  assign diff_a  = (18'(in_data.phase_a) <<< 1) - 18'(in_data.phase_b)
                   - 18'(in_data.phase_c);
  assign diff_bc = 17'(in_data.phase_b) - 17'(in_data.phase_c);

  assign alpha_prod = 32'(diff_a) * 32'(foc_pkg::K_THIRD);
  assign beta_prod  = 32'(diff_bc) * 32'(foc_pkg::K_INV_SQRT3);
  assign alpha_nxt  = 25'((alpha_prod + 32'sd64) >>> (15 - foc_pkg::EXTRA_BITS));
  assign beta_nxt   = 25'((beta_prod + 32'sd64) >>> (15 - foc_pkg::EXTRA_BITS));

  ab_t              s1_alpha_r, s2_alpha_r, s3_alpha_r, s4_alpha_r;
  ab_t              s1_beta_r, s2_beta_r, s3_beta_r, s4_beta_r;
  foc_pkg::sample_t s1_qr_r, s2_qr_r, s3_qr_r, s4_qr_r, s5_qr_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_alpha_r <= alpha_nxt;
      s1_beta_r  <= beta_nxt;
      s1_qr_r    <= in_data.q_reference;
    end
  end

  // stages 2 to 4: wait for the trig pipeline
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_alpha_r <= s1_alpha_r;
      s2_beta_r  <= s1_beta_r;
      s2_qr_r    <= s1_qr_r;
    end
    if (en[3]) begin
      s3_alpha_r <= s2_alpha_r;
      s3_beta_r  <= s2_beta_r;
      s3_qr_r    <= s2_qr_r;
    end
    if (en[4]) begin
      s4_alpha_r <= s3_alpha_r;
      s4_beta_r  <= s3_beta_r;
      s4_qr_r    <= s3_qr_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 5: park products
  // ---------------------------------------------------------------------
  prod1_t p_ac_r, p_bs_r, p_bc_r, p_as_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      p_ac_r  <= 42'(s4_alpha_r) * 42'(cos_v);
      p_bs_r  <= 42'(s4_beta_r) * 42'(sin_v);
      p_bc_r  <= 42'(s4_beta_r) * 42'(cos_v);
      p_as_r  <= 42'(s4_alpha_r) * 42'(sin_v);
      s5_qr_r <= s4_qr_r;
    end
  end

  // sin and cos ride along for the inverse park
  foc_pkg::trig_t s5_sin_r, s5_cos_r, s6_sin_r, s6_cos_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_sin_r <= sin_v;
      s5_cos_r <= cos_v;
    end
    if (en[6]) begin
      s6_sin_r <= s5_sin_r;
      s6_cos_r <= s5_cos_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 6: d/q sums and regulator errors (unit gain, no integral)
  // ed = -d, eq = q_ref - q
  // ---------------------------------------------------------------------
  logic signed [42:0] d_sum, q_sum;
  err_t               d_val, q_val, ed_nxt, eq_nxt;

  assign d_sum  = 43'(p_ac_r) + 43'(p_bs_r);
  assign q_sum  = 43'(p_bc_r) - 43'(p_as_r);
  assign d_val  = 26'((d_sum + 43'sd16384) >>> 15);
  assign q_val  = 26'((q_sum + 43'sd16384) >>> 15);
  assign ed_nxt = -d_val;
  assign eq_nxt = (26'(s5_qr_r) <<< foc_pkg::EXTRA_BITS) - q_val;

  err_t s6_ed_r, s6_eq_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_ed_r <= ed_nxt;
      s6_eq_r <= eq_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 7: inverse park products
  // ---------------------------------------------------------------------
  prod2_t p_ec_r, p_qs_r, p_es_r, p_qc_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      p_ec_r <= 43'(s6_ed_r) * 43'(s6_cos_r);
      p_qs_r <= 43'(s6_eq_r) * 43'(s6_sin_r);
      p_es_r <= 43'(s6_ed_r) * 43'(s6_sin_r);
      p_qc_r <= 43'(s6_eq_r) * 43'(s6_cos_r);
    end
  end

  // ---------------------------------------------------------------------
  // stage 8: inverse park sums
  // ---------------------------------------------------------------------
  foc_pkg::wide_t al_sum, be_sum;
  ab2_t           al_nxt, be_nxt;

  assign al_sum = foc_pkg::wide_t'(p_ec_r) - foc_pkg::wide_t'(p_qs_r);
  assign be_sum = foc_pkg::wide_t'(p_es_r) + foc_pkg::wide_t'(p_qc_r);
  assign al_nxt = 27'((al_sum + 44'sd16384) >>> 15);
  assign be_nxt = 27'((be_sum + 44'sd16384) >>> 15);

  ab2_t s8_al_r, s8_be_r, s9_al_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_al_r <= al_nxt;
      s8_be_r <= be_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 9: sqrt3/2 * beta for the inverse clarke
  // ---------------------------------------------------------------------
  prod2_t s9_m_r;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s9_m_r  <= 43'(s8_be_r) * 43'(foc_pkg::K_SQRT3_HALF);
      s9_al_r <= s8_al_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 10: inverse clarke, round to sample lsb, saturate
  // v = -al/2 + sqrt3/2 be, w = -al/2 - sqrt3/2 be
  // ---------------------------------------------------------------------
  foc_pkg::wide_t al_w, half_w, m_w, u_w, v_w, w_w;
  foc_pkg::out_t  out_nxt;

  assign al_w   = foc_pkg::wide_t'(s9_al_r);
  assign m_w    = foc_pkg::wide_t'(s9_m_r);
  assign half_w = al_w <<< 14;
  assign u_w    = (al_w + RND_U) >>> foc_pkg::EXTRA_BITS;
  assign v_w    = (m_w - half_w + RND_VW) >>> (15 + foc_pkg::EXTRA_BITS);
  assign w_w    = (-half_w - m_w + RND_VW) >>> (15 + foc_pkg::EXTRA_BITS);

  always_comb begin
    out_nxt.drive_u = foc_pkg::sat_sample(u_w);
    out_nxt.drive_v = foc_pkg::sat_sample(v_w);
    out_nxt.drive_w = foc_pkg::sat_sample(w_w);
  end

  foc_pkg::out_t out_data_r;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_data = out_data_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
`ifndef NO_ASSERTIONS
  // a free output side must never back-pressure the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output side is ready");

  // reset empties the whole pipeline
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // a request accepted into an empty first stage occupies it in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !vld_r[1] && (&en) |=> vld_r[1])
    else $error("accepted request did not enter the first stage");
`endif

endmodule

`default_nettype wire

// File: test/tb_foc_transform_chain_unit.sv
// testbench for the foc clarke/park transform chain unit
`default_nettype none

module tb_foc_transform_chain_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // q15 transform constants
  localparam longint THIRD_Q15      = 10923;  // 1/3
  localparam longint INV_SQRT3_Q15  = 18919;  // 1/sqrt3
  localparam longint SQRT3_HALF_Q15 = 28378;  // sqrt3/2
  localparam longint HALF_Q15       = 16384;  // 1/2
  localparam longint GUARD_BITS     = 8;      // fraction bits below the sample lsb

  // quarter-wave sine polynomial, q15
  localparam longint SINE_A = 51472;
  localparam longint SINE_B = 21024;
  localparam longint SINE_C = 2320;

  localparam longint SAMPLE_MAX = 32767;
  localparam longint SAMPLE_MIN = -32768;

  // drain wait after the last result, well above the ten-stage pipeline
  localparam int DRAIN_CYCLES = 40;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  foc_pkg::in_t   in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  foc_pkg::out_t  out_data;

  // idle switches for the request side and the result side
  bit sender_idles = 1'b0;
  bit receiver_idles = 1'b0;

  // drive values expected back, oldest first
  foc_pkg::out_t expected_drive[$];
  int            error_count = 0;
  int            result_count = 0;

  foc_transform_chain_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // floor((x + 2^(k-1)) / 2^k), arithmetic shift keeps negative values right
  function automatic longint round_shift(longint x, int k);
    longint bias;
    bias = longint'(1) <<< (k - 1);
    return (x + bias) >>> k;
  endfunction

  // sine magnitude over one quarter, z in q14, result q15 capped at 1.0
  function automatic longint quarter_sine_mag(longint z);
    longint z2;
    longint t;
    longint u;
    longint s;
    z2 = (z * z + 8192) >>> 14;
    t  = (SINE_C * z2 + 8192) >>> 14;
    u  = ((SINE_B - t) * z2 + 8192) >>> 14;
    s  = ((SINE_A - u) * z + 8192) >>> 14;
    return (s > 32768) ? 32768 : s;
  endfunction

  // signed q15 sine of a 16-bit phase, quarters 1 and 3 mirrored, 2 and 3 negated
  function automatic longint rom_sine(logic [15:0] phase);
    longint z;
    longint s;
    z = longint'(phase[13:0]);
    if (phase[14]) begin
      z = 16384 - z;
    end
    s = quarter_sine_mag(z);
    return phase[15] ? -s : s;
  endfunction

  function automatic foc_pkg::sample_t clamp_sample(longint v);
    if (v > SAMPLE_MAX) begin
      v = SAMPLE_MAX;
    end else if (v < SAMPLE_MIN) begin
      v = SAMPLE_MIN;
    end
    return foc_pkg::sample_t'(v);
  endfunction

  // clarke, park, unit-gain error, inverse park, inverse clarke
  function automatic foc_pkg::out_t predict_drive(foc_pkg::in_t req);
    longint        a, b, c, qr;
    logic [15:0]   phase;
    longint        st, ct;
    longint        alpha, beta, d, q, ed, eq, al, be;
    foc_pkg::out_t res;
    a     = longint'($signed(req.phase_a));
    b     = longint'($signed(req.phase_b));
    c     = longint'($signed(req.phase_c));
    qr    = longint'($signed(req.q_reference));
    phase = {req.rotor_angle, 4'b0000};
    st    = rom_sine(phase);
    ct    = rom_sine(phase + 16'h4000);
    alpha = round_shift((2 * a - b - c) * THIRD_Q15, 15 - GUARD_BITS);
    beta  = round_shift((b - c) * INV_SQRT3_Q15, 15 - GUARD_BITS);
    d     = round_shift(alpha * ct + beta * st, 15);
    q     = round_shift(beta * ct - alpha * st, 15);
    ed    = -d;
    eq    = qr * (longint'(1) <<< GUARD_BITS) - q;
    al    = round_shift(ed * ct - eq * st, 15);
    be    = round_shift(ed * st + eq * ct, 15);
    res.drive_u = clamp_sample(round_shift(al, GUARD_BITS));
    res.drive_v = clamp_sample(round_shift(-HALF_Q15 * al + SQRT3_HALF_Q15 * be,
                                           15 + GUARD_BITS));
    res.drive_w = clamp_sample(round_shift(-HALF_Q15 * al - SQRT3_HALF_Q15 * be,
                                           15 + GUARD_BITS));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic compare_field(input string name, input foc_pkg::sample_t got,
                               input foc_pkg::sample_t want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                result_count, name, got, want));
    end
  endtask

  // both handshakes sampled at the edge; the request is logged before the
  // result is checked, though the pipeline never returns a result in the cycle its request is taken
  always @(posedge clk) begin : scoreboard
    foc_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_drive.push_back(predict_drive(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_drive.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request pending: %h",
                                    result_count, out_data));
        end else begin
          want = expected_drive.pop_front();
          compare_field("drive_u", out_data.drive_u, want.drive_u);
          compare_field("drive_v", out_data.drive_v, want.drive_v);
          compare_field("drive_w", out_data.drive_w, want.drive_w);
        end
        result_count++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // idling and result-side backpressure
  // ---------------------------------------------------------------------------

  // mostly none or short, now and then a long pause
  function automatic int idle_cycles(bit enabled);
    int unsigned pick;
    if (!enabled) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return 0;
    end else if (pick < 85) begin
      return $urandom_range(1, 3);
    end else if (pick < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // out_ready only ever gets one assignment per edge
  initial begin : result_sink
    int hold;
    int run;
    wait (rst_n === 1'b1);
    forever begin
      hold = idle_cycles(receiver_idles);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // valid stays up across back-to-back requests; it only drops when a gap
  // is taken, so it is never lowered and raised in the same step
  task automatic send_request(input foc_pkg::in_t req);
    int gap;
    gap = idle_cycles(sender_idles);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic foc_pkg::in_t make_request(longint a, longint b, longint c,
                                                int unsigned angle, longint qr);
    foc_pkg::in_t req;
    req.phase_a     = foc_pkg::sample_t'(a);
    req.phase_b     = foc_pkg::sample_t'(b);
    req.phase_c     = foc_pkg::sample_t'(c);
    req.rotor_angle = angle[11:0];
    req.q_reference = foc_pkg::sample_t'(qr);
    return req;
  endfunction

  // full range most of the time, with the corners of q1.15 mixed in
  function automatic longint random_sample();
    if ($urandom_range(0, 9) < 2) begin
      case ($urandom_range(0, 5))
        0:       return SAMPLE_MIN;
        1:       return SAMPLE_MAX;
        2:       return 0;
        3:       return -1;
        4:       return 1;
        default: return SAMPLE_MIN + 1;
      endcase
    end
    return longint'($signed(16'($urandom)));
  endfunction

  function automatic int unsigned random_angle();
    if ($urandom_range(0, 9) == 0) begin
      // quadrant boundaries and their neighbors
      return ($urandom_range(0, 3) * 1024 + $urandom_range(0, 2) + 4095) % 4096;
    end
    return $urandom_range(0, 4095);
  endfunction

  function automatic foc_pkg::in_t random_request();
    longint a, b;
    if ($urandom_range(0, 99) < 25) begin
      // balanced three-phase set, a + b + c = 0 as on a real machine
      a = longint'($urandom_range(0, 32766)) - 16383;
      b = longint'($urandom_range(0, 32766)) - 16383;
      return make_request(a, b, -(a + b), random_angle(), random_sample());
    end
    return make_request(random_sample(), random_sample(), random_sample(),
                        random_angle(), random_sample());
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // zero, all-max, all-min and mixed sign corners
  task automatic test_field_extremes();
    send_request(make_request(0, 0, 0, 0, 0));
    send_request(make_request(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 4095, SAMPLE_MAX));
    send_request(make_request(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 0, SAMPLE_MIN));
    send_request(make_request(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 2048, SAMPLE_MIN));
    send_request(make_request(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1024, SAMPLE_MAX));
    send_request(make_request(-1, 1, 0, 3072, -1));
  endtask

  // one fixed current set turned through the sine table quadrants
  task automatic test_angle_quadrants();
    int unsigned angles[8] = '{0, 1, 1023, 1024, 1025, 2048, 3072, 4095};
    foreach (angles[i]) begin
      send_request(make_request(12000, -5000, -7000, angles[i], 9000));
    end
  endtask

  // amplitudes past full scale so the drive values clamp, drive_u both ways
  task automatic test_drive_saturation();
    send_request(make_request(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 0, 0));
    send_request(make_request(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 0, 0));
    send_request(make_request(0, SAMPLE_MAX, SAMPLE_MIN, 1024, SAMPLE_MAX));
    send_request(make_request(0, SAMPLE_MIN, SAMPLE_MAX, 3072, SAMPLE_MIN));
    send_request(make_request(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, 512, SAMPLE_MAX));
    send_request(make_request(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 2560, SAMPLE_MIN));
  endtask

  // one request per cycle with the result side always open
  task automatic test_full_rate_burst(input int count);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    repeat (count) send_request(random_request());
  endtask

  // random requests in phases, each with its own idle pattern, so stalls
  // land on every pipeline stage and some phases run with no gaps at all
  task automatic test_random_traffic(input int phases, input int per_phase);
    repeat (phases) begin
      sender_idles   = $urandom_range(0, 2) != 0;
      receiver_idles = $urandom_range(0, 2) != 0;
      repeat (per_phase) send_request(random_request());
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests go out with gaps on both sides
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    test_field_extremes();
    test_angle_quadrants();
    test_drive_saturation();

    test_full_rate_burst(100);
    test_random_traffic(13, 100);
    drain_results();

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop, many times the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
